[hw/rtl/frbc_pkg.sv]
// Shared constants, types and helpers of the FIFO-replacement block cache.
package frbc_pkg;

   localparam int CAPACITY    = 16;
   localparam int HANDLE_BITS = 32;

   localparam int KEY_BITS    = 64;
   localparam int IN_HANDLE_BITS = 32;
   localparam int SLOT_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int LIMIT_BITS  = 5;
   localparam int CMP_BITS    = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
   localparam int ENTRY_BITS  = KEY_BITS + HANDLE_BITS;

   localparam int REQ_TDATA_BITS = 96;
   localparam int RSP_TDATA_BITS = 40;

   localparam logic [LIMIT_BITS-1:0] MAX_ENTRIES_RESET = 5'd16;

   localparam logic [1:0] OP_ADD        = 2'd0;
   localparam logic [1:0] OP_LOOKUP     = 2'd1;
   localparam logic [1:0] OP_INVALIDATE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      entry_type            wr_data;
      logic [SLOT_BITS-1:0] rd_addr;
   } ram_cmd_type;

   // (slot + off) mod CAPACITY, valid while off <= CAPACITY
   function automatic logic [SLOT_BITS-1:0] ring_add(input logic [SLOT_BITS-1:0] slot,
                                                     input logic [COUNT_BITS-1:0] off);
      logic [COUNT_BITS:0] sum;
      sum = (COUNT_BITS+1)'(slot) + (COUNT_BITS+1)'(off);
      if (sum >= (COUNT_BITS+1)'(CAPACITY)) begin
         sum = sum - (COUNT_BITS+1)'(CAPACITY);
      end
      return SLOT_BITS'(sum);
   endfunction

   function automatic logic [SLOT_BITS-1:0] ring_inc(input logic [SLOT_BITS-1:0] slot);
      logic [SLOT_BITS-1:0] nxt;
      if (slot == SLOT_BITS'(CAPACITY - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + SLOT_BITS'(1);
      end
      return nxt;
   endfunction

endpackage

[hw/rtl/frbc_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module frbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/frbc_engine.sv]
// Command sequencer: add / lookup scan / invalidate over the entry RAM, result register.
module frbc_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [frbc_pkg::COUNT_BITS-1:0]     limit,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [frbc_pkg::KEY_BITS-1:0]       req_key,
   input  logic [frbc_pkg::IN_HANDLE_BITS-1:0] req_handle,
   output frbc_pkg::ram_cmd_type               ram_cmd,
   input  frbc_pkg::entry_type                 ram_rd_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [frbc_pkg::IN_HANDLE_BITS-1:0] rsp_handle,
   output logic                                rsp_evicted
);

   frbc_pkg::state_type state_ff, state_in;

   logic [1:0]                          op_ff, op_in;
   logic [frbc_pkg::KEY_BITS-1:0]       key_ff, key_in;
   logic [frbc_pkg::IN_HANDLE_BITS-1:0] handle_ff, handle_in;

   logic [frbc_pkg::SLOT_BITS-1:0]  oldest_ff, oldest_in;
   logic [frbc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [frbc_pkg::COUNT_BITS-1:0] idx_ff, idx_in;
   logic [frbc_pkg::SLOT_BITS-1:0]  scan_slot_ff, scan_slot_in;
   logic                            pend_ff, pend_in;
   logic                            hit_ff, hit_in;
   logic [frbc_pkg::IN_HANDLE_BITS-1:0] found_ff, found_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_hit_ff, rsp_hit_in;
   logic [frbc_pkg::IN_HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic                                rsp_evicted_ff, rsp_evicted_in;

   logic                            out_free;
   logic                            evict;
   logic                            issue;
   logic                            match;
   logic [frbc_pkg::COUNT_BITS-1:0] drop;
   logic [frbc_pkg::SLOT_BITS-1:0]  add_oldest;
   logic [frbc_pkg::COUNT_BITS-1:0] add_base;
   logic [frbc_pkg::SLOT_BITS-1:0]  add_slot;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // add: drop oldest entries until the new one fits under the limit
   assign evict      = (count_ff >= limit);
   assign drop       = count_ff - limit + frbc_pkg::COUNT_BITS'(1);
   assign add_oldest = evict ? frbc_pkg::ring_add(oldest_ff, drop) : oldest_ff;
   assign add_base   = evict ? (limit - frbc_pkg::COUNT_BITS'(1)) : count_ff;
   assign add_slot   = frbc_pkg::ring_add(add_oldest, add_base);

   assign issue = (idx_ff != count_ff);
   assign match = pend_ff && (ram_rd_data.key == key_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      handle_in      = handle_ff;
      oldest_in      = oldest_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      scan_slot_in   = scan_slot_ff;
      pend_in        = 1'b0;
      hit_in         = hit_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_evicted_in = rsp_evicted_ff;

      ram_cmd.wr_en   = 1'b0;
      ram_cmd.wr_addr = add_slot;
      ram_cmd.wr_data.key    = key_ff;
      ram_cmd.wr_data.handle = frbc_pkg::HANDLE_BITS'(handle_ff);
      ram_cmd.rd_addr = scan_slot_ff;

      case (state_ff)
         frbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_opcode;
               key_in    = req_key;
               handle_in = req_handle;
               state_in  = frbc_pkg::ST_EXEC;
            end
         end
         frbc_pkg::ST_EXEC: begin
            if (op_ff == frbc_pkg::OP_LOOKUP) begin
               idx_in       = '0;
               scan_slot_in = oldest_ff;
               state_in     = frbc_pkg::ST_SCAN;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = 1'b0;
               rsp_handle_in  = '0;
               rsp_evicted_in = 1'b0;
               state_in       = frbc_pkg::ST_IDLE;
               case (op_ff)
                  frbc_pkg::OP_ADD: begin
                     ram_cmd.wr_en  = 1'b1;
                     oldest_in      = add_oldest;
                     count_in       = add_base + frbc_pkg::COUNT_BITS'(1);
                     rsp_evicted_in = evict;
                  end
                  frbc_pkg::OP_INVALIDATE: begin
                     oldest_in = '0;
                     count_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         frbc_pkg::ST_SCAN: begin
            // read of entry idx-1 lands now; first match (oldest) wins
            if (match) begin
               hit_in   = 1'b1;
               found_in = frbc_pkg::IN_HANDLE_BITS'(ram_rd_data.handle);
               state_in = frbc_pkg::ST_DONE;
            end else if (!issue && !pend_ff) begin
               hit_in   = 1'b0;
               found_in = '0;
               state_in = frbc_pkg::ST_DONE;
            end else begin
               pend_in = issue;
               if (issue) begin
                  idx_in       = idx_ff + frbc_pkg::COUNT_BITS'(1);
                  scan_slot_in = frbc_pkg::ring_inc(scan_slot_ff);
               end
            end
         end
         frbc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = hit_ff;
               rsp_handle_in  = found_ff;
               rsp_evicted_in = 1'b0;
               state_in       = frbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frbc_pkg::ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      handle_ff      <= handle_in;
      idx_ff         <= idx_in;
      scan_slot_ff   <= scan_slot_in;
      hit_ff         <= hit_in;
      found_ff       <= found_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign req_ready   = (state_ff == frbc_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_handle  = rsp_handle_ff;
   assign rsp_evicted = rsp_evicted_ff;

endmodule

[hw/rtl/fifo_replacement_block_cache.sv]
// Top level of the FIFO-replacement block cache.
// A fully associative table of 64-bit block keys with buffer handles, kept as a ring in one
// RAM and replaced oldest first. Every request beat (opcode in req_tuser: add, lookup,
// invalidate all) returns exactly one response beat. A lookup reads one entry per cycle
// through the single RAM read port, oldest first, stopping at the first match; it reads at
// most the current fill, 16 entries with the default capacity. A finished response sits in
// an output register, so the next request is taken while it waits. csr_wdata sets the entry
// limit (0 acts as 1, values above the capacity act as the capacity); write it only while
// the block is idle. The RAM needs no clearing after reset.
module fifo_replacement_block_cache (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [frbc_pkg::LIMIT_BITS-1:0]     csr_wdata,      // max_entries
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [frbc_pkg::REQ_TDATA_BITS-1:0] req_tdata,      // block_key, buffer_handle
   input  logic [1:0]                          req_tuser,      // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [frbc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,      // found_handle, evicted, pad
   output logic                                rsp_tuser       // hit
);

   logic [frbc_pkg::LIMIT_BITS-1:0] max_entries_ff, max_entries_in;
   logic [frbc_pkg::CMP_BITS-1:0]   limit_wide;
   logic [frbc_pkg::COUNT_BITS-1:0] limit;

   frbc_pkg::ram_cmd_type ram_cmd;
   frbc_pkg::entry_type   ram_rd_data;
   logic [frbc_pkg::ENTRY_BITS-1:0] ram_rd_bits;

   logic                                rsp_hit;
   logic [frbc_pkg::IN_HANDLE_BITS-1:0] rsp_handle;
   logic                                rsp_evicted;

   assign max_entries_in = csr_we ? csr_wdata : max_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= frbc_pkg::MAX_ENTRIES_RESET;
      end else begin
         max_entries_ff <= max_entries_in;
      end
   end

   always_comb begin
      limit_wide = frbc_pkg::CMP_BITS'(max_entries_ff);
      if (limit_wide == '0) begin
         limit_wide = frbc_pkg::CMP_BITS'(1);
      end else if (limit_wide > frbc_pkg::CMP_BITS'(frbc_pkg::CAPACITY)) begin
         limit_wide = frbc_pkg::CMP_BITS'(frbc_pkg::CAPACITY);
      end
      limit = frbc_pkg::COUNT_BITS'(limit_wide);
   end

   frbc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .limit       (limit),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tuser),
      .req_key     (req_tdata[63:0]),
      .req_handle  (req_tdata[95:64]),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_hit     (rsp_hit),
      .rsp_handle  (rsp_handle),
      .rsp_evicted (rsp_evicted)
   );

   frbc_ram #(
      .WIDTH (frbc_pkg::ENTRY_BITS),
      .DEPTH (frbc_pkg::CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = ram_rd_bits;

   assign rsp_tdata = {7'd0, rsp_evicted, rsp_handle};
   assign rsp_tuser = rsp_hit;

endmodule

[hw/rtl/frbc_checker.sv]
// Port-level checker for the FIFO-replacement block cache, bound to the top level.
module frbc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [frbc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                                rsp_tuser
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // only a lookup hits, only an add evicts
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tdata[32]))
      else $error("hit and eviction in the same beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero handle without hit");

   // one request in flight: an accepted beat blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

endmodule

bind fifo_replacement_block_cache frbc_checker u_frbc_checker (.*);

[verif/tb.sv]
// Testbench for the FIFO-replacement block cache: scoreboard and stream drivers.
`timescale 1ns / 1ps

module tb;
   import frbc_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int POOL_SIZE = 6;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic                   hit;
      logic [HANDLE_BITS-1:0] handle;
      logic                   evicted;
   } cache_result_type;

   // Mirror of the cache contents; predicts one result per accepted request.
   class block_cache_scoreboard;
      logic [KEY_BITS-1:0]    keys[CAPACITY];
      logic [HANDLE_BITS-1:0] handles[CAPACITY];
      int unsigned oldest;
      int unsigned fill;
      logic [LIMIT_BITS-1:0] limit_reg;
      cache_result_type awaited_results[$];
      int errors;

      function new();
         oldest = 0;
         fill = 0;
         limit_reg = MAX_ENTRIES_RESET;
         errors = 0;
      endfunction

      function void set_limit(logic [LIMIT_BITS-1:0] value);
         limit_reg = value;
      endfunction

      function void note_request(logic [1:0] op, logic [KEY_BITS-1:0] key,
                                 logic [IN_HANDLE_BITS-1:0] hdl);
         cache_result_type r;
         int unsigned lim;
         int unsigned drop;
         int unsigned slot;
         r = '0;
         if (op == OP_ADD) begin
            lim = (limit_reg == 0) ? 1 : ((limit_reg > CAPACITY) ? CAPACITY : limit_reg);
            if (fill >= lim) begin
               // a lowered limit can drop several entries at once
               drop = fill - lim + 1;
               oldest = (oldest + drop) % CAPACITY;
               fill = fill - drop;
               r.evicted = 1'b1;
            end
            slot = (oldest + fill) % CAPACITY;
            keys[slot] = key;
            handles[slot] = HANDLE_BITS'(hdl);
            fill++;
         end else if (op == OP_LOOKUP) begin
            for (int unsigned i = 0; i < fill; i++) begin
               slot = (oldest + i) % CAPACITY;
               if (keys[slot] == key) begin
                  r.hit = 1'b1;
                  r.handle = handles[slot];
                  break;
               end
            end
         end else if (op == OP_INVALIDATE) begin
            oldest = 0;
            fill = 0;
         end
         awaited_results.insert(awaited_results.size(), r);
      endfunction

      function void check_response(logic hit, logic [HANDLE_BITS-1:0] hdl, logic evicted);
         cache_result_type exp_r;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected response beat hit=%0b handle=%h evicted=%0b",
                     $time, hit, hdl, evicted);
            errors++;
            return;
         end
         exp_r = awaited_results[0];
         awaited_results.delete(0);
         if (hit !== exp_r.hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, exp_r.hit, hit);
            errors++;
         end
         if (hdl !== exp_r.handle) begin
            $display("%0t: found_handle mismatch, expected %h actual %h",
                     $time, exp_r.handle, hdl);
            errors++;
         end
         if (evicted !== exp_r.evicted) begin
            $display("%0t: evicted mismatch, expected %0b actual %0b",
                     $time, exp_r.evicted, evicted);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [LIMIT_BITS-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;   // block_key, buffer_handle
   logic [1:0] req_tuser = '0;                  // opcode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;        // found_handle, evicted, pad
   logic rsp_tuser;                             // hit

   block_cache_scoreboard sb = new();

   logic hold_request = 1'b0;
   int hold_left = 0;
   int pattern_left = 0;
   int stall_mode = 0;
   int unsigned rx_cycle = 0;
   int unsigned cycles = 0;
   logic [KEY_BITS-1:0] key_pool[POOL_SIZE];

   fifo_replacement_block_cache u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: checks beats, stalls on its own changing pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tuser, rsp_tdata[HANDLE_BITS-1:0], rsp_tdata[HANDLE_BITS]);
         end
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request <= 1'b0;
         end
         if (pattern_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 80);
         end else begin
            pattern_left--;
         end
         rx_cycle++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 9) != 0);
               default: rsp_tready <= (rx_cycle[1:0] != 2'd0);
            endcase
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                            input logic [IN_HANDLE_BITS-1:0] hdl);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {hdl, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, key, hdl);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_limit(value);
   endtask

   task automatic run_random(input int n, input logic [LIMIT_BITS-1:0] lim,
                             input bit with_hold);
      int burst_left;
      int r;
      bit gappy;
      logic [1:0] op;
      logic [KEY_BITS-1:0] key;
      write_limit(lim);
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      gappy = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 46) op = OP_ADD;
         else if (r < 93) op = OP_LOOKUP;
         else if (r < 96) op = OP_INVALIDATE;
         else op = OP_UNUSED;
         if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else key = {$urandom, $urandom};
         send_item(op, key, $urandom);
         if (with_hold && i == 10) hold_request <= 1'b1;
         burst_left--;
         if (burst_left == 0) begin
            if (gappy) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            burst_left = $urandom_range(1, 20);
         end
      end
   endtask

   initial begin
      logic [KEY_BITS-1:0] ones_key;
      ones_key = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, extremes of key and handle, duplicate keys, unused opcode
      send_item(OP_LOOKUP, '0, '0);
      send_item(OP_ADD, '0, '0);
      send_item(OP_ADD, ones_key, '1);
      send_item(OP_LOOKUP, ones_key, '0);
      send_item(OP_LOOKUP, '0, '1);
      send_item(OP_ADD, '0, 32'h5A5A_A5A5);
      send_item(OP_LOOKUP, '0, '0);
      send_item(OP_UNUSED, 64'hDEAD_BEEF_0123_4567, 32'h89AB_CDEF);
      send_item(OP_LOOKUP, ones_key, '0);
      send_item(OP_INVALIDATE, 64'h1234, 32'h5678);
      send_item(OP_LOOKUP, ones_key, '0);

      // limit of two: third add evicts the oldest
      write_limit(5'd2);
      send_item(OP_ADD, 64'h11, 32'h1);
      send_item(OP_ADD, 64'h22, 32'h2);
      send_item(OP_ADD, 64'h33, 32'h3);
      send_item(OP_LOOKUP, 64'h11, '0);
      send_item(OP_LOOKUP, 64'h33, '0);

      // limit lowered below the fill: one add drops several entries
      write_limit(5'd16);
      for (int i = 0; i < 6; i++) send_item(OP_ADD, 64'(i + 64'h100), 32'(i + 32'h40));
      write_limit(5'd3);
      send_item(OP_ADD, 64'h200, 32'hFEED);
      send_item(OP_LOOKUP, 64'h103, '0);
      send_item(OP_LOOKUP, 64'h104, '0);

      run_random(120, 5'd0, 1'b0);
      run_random(120, 5'd16, 1'b0);
      run_random(120, 5'd31, 1'b1);
      run_random(120, 5'd1, 1'b0);
      run_random(120, 5'd4, 1'b0);
      run_random(130, 5'($urandom_range(0, 31)), 1'b0);
      run_random(120, 5'd16, 1'b0);

      drain();
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
